@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

@@ rtl/dsfp_pkg.sv @@
// ---------------------------------------------------------------------------
// Dust sensor frame parser package
// Frame constants, queue depth and the operation passed from front to back.
// ---------------------------------------------------------------------------
package dsfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'hC0;
  localparam logic [7:0] FRAME_TAIL = 8'hAB;

  localparam logic [3:0] POS_HUNT       = 4'd0;
  localparam logic [3:0] POS_HDR2       = 4'd1;
  localparam logic [3:0] POS_DATA_FIRST = 4'd2;
  localparam logic [3:0] POS_DATA_LAST  = 4'd7;
  localparam logic [3:0] POS_STORE_END  = 4'd6;
  localparam logic [3:0] POS_CHECK      = 4'd8;
  localparam logic [3:0] POS_TAIL       = 4'd9;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_CHECK = 2'd2,
    OP_TAIL  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic        store;
    logic [1:0]  slot;
    logic [7:0]  data;
  } op_t;

endpackage

@@ rtl/dsfp_front.sv @@
// ---------------------------------------------------------------------------
// Dust sensor frame parser front end
// Tracks frame position; accepted bytes from header C0 on become operations.
// ---------------------------------------------------------------------------
module dsfp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  output logic            push,
  output dsfp_pkg::op_t   op
);

  logic [3:0] position;
  logic [3:0] position_next;
  logic [3:0] slot_wide;

  assign slot_wide = position - dsfp_pkg::POS_DATA_FIRST;

  always_comb begin
    position_next = position;
    push          = 1'b0;
    op.kind       = dsfp_pkg::OP_DATA;
    op.store      = 1'b0;
    op.slot       = slot_wide[1:0];
    op.data       = rx_byte;
    if (accept) begin
      if (position == dsfp_pkg::POS_HUNT) begin
        if (rx_byte == dsfp_pkg::HDR_FIRST) begin
          position_next = dsfp_pkg::POS_HDR2;
        end
      end else if (position == dsfp_pkg::POS_HDR2) begin
        if (rx_byte == dsfp_pkg::HDR_SECOND) begin
          position_next = dsfp_pkg::POS_DATA_FIRST;
          push          = 1'b1;
          op.kind       = dsfp_pkg::OP_START;
        end else begin
          position_next = dsfp_pkg::POS_HUNT;
        end
      end else if (position <= dsfp_pkg::POS_DATA_LAST) begin
        position_next = position + 4'd1;
        push          = 1'b1;
        op.kind       = dsfp_pkg::OP_DATA;
        op.store      = (position < dsfp_pkg::POS_STORE_END);
      end else if (position == dsfp_pkg::POS_CHECK) begin
        position_next = dsfp_pkg::POS_TAIL;
        push          = 1'b1;
        op.kind       = dsfp_pkg::OP_CHECK;
      end else if (position == dsfp_pkg::POS_TAIL) begin
        position_next = dsfp_pkg::POS_HUNT;
        push          = 1'b1;
        op.kind       = dsfp_pkg::OP_TAIL;
      end else begin
        position_next = dsfp_pkg::POS_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= dsfp_pkg::POS_HUNT;
    end else begin
      position <= position_next;
    end
  end

endmodule

@@ rtl/dsfp_fifo.sv @@
// ---------------------------------------------------------------------------
// Dust sensor frame parser operation queue
// Short first-in first-out queue between front end and back end.
// ---------------------------------------------------------------------------
module dsfp_fifo #(
  parameter int DEPTH = dsfp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dsfp_pkg::op_t   push_op,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output dsfp_pkg::op_t   head_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dsfp_pkg::op_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_op   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/dsfp_back.sv @@
// ---------------------------------------------------------------------------
// Dust sensor frame parser back end
// Runs the checksum, holds the reading bytes and drives the result register.
// ---------------------------------------------------------------------------
module dsfp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_valid,
  input  dsfp_pkg::op_t   op,
  output logic            pop,
  output logic            reading_valid,
  input  logic            reading_stall,
  output logic [15:0]     pm25_tenths,
  output logic [15:0]     pm10_tenths
);

  logic [7:0] running_sum;
  logic       sum_matched;
  logic [7:0] reading_bytes [4];
  logic       out_free;
  logic       emit;

  assign out_free = !reading_valid || !reading_stall;
  assign pop      = op_valid && ((op.kind != dsfp_pkg::OP_TAIL) || out_free);
  assign emit     = pop && (op.kind == dsfp_pkg::OP_TAIL) &&
                    (op.data == dsfp_pkg::FRAME_TAIL) && sum_matched;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      sum_matched <= 1'b0;
    end else if (pop) begin
      case (op.kind)
        dsfp_pkg::OP_START: begin
          running_sum <= '0;
          sum_matched <= 1'b0;
        end
        dsfp_pkg::OP_DATA: begin
          running_sum <= running_sum + op.data;
        end
        dsfp_pkg::OP_CHECK: begin
          sum_matched <= (op.data == running_sum);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (op.kind == dsfp_pkg::OP_DATA) && op.store) begin
      reading_bytes[op.slot] <= op.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading_valid <= 1'b0;
    end else if (emit) begin
      reading_valid <= 1'b1;
    end else if (!reading_stall) begin
      reading_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pm25_tenths <= {reading_bytes[1], reading_bytes[0]};
      pm10_tenths <= {reading_bytes[3], reading_bytes[2]};
    end
  end

endmodule

@@ rtl/dust_sensor_frame_parser.sv @@
// Result: an accepted tail byte is queued, and reading_valid is registered
// when it is popped with the result register free. Throughput: one byte
// per cycle unless byte_stall is high; front end, queue and back end each
// move one transaction per cycle, and the queue depth sets how many frame
// transactions are taken behind a held tail while the result is stalled.
// Reset: synchronous, active high; clears the frame position, checksum
// state, queue pointers and result valid. Reading bytes are not cleared.
// ---------------------------------------------------------------------------
// Dust sensor frame parser
// Recognises ten-byte sensor frames and emits PM2.5 and PM10 readings.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dust_sensor_frame_parser #(
  parameter int QUEUE_DEPTH = dsfp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  output logic        reading_valid,
  input  logic        reading_stall,
  output logic [15:0] pm25_tenths,
  output logic [15:0] pm10_tenths
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  logic          accept;
  dsfp_pkg::op_t front_op;
  dsfp_pkg::op_t q_op;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;

  dsfp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .push    (q_push),
    .op      (front_op)
  );

  dsfp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_op   (front_op),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_op   (q_op)
  );

  dsfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .op_valid      (q_valid),
    .op            (q_op),
    .pop           (q_pop),
    .reading_valid (reading_valid),
    .reading_stall (reading_stall),
    .pm25_tenths   (pm25_tenths),
    .pm10_tenths   (pm10_tenths)
  );

  `ASSERT_IMPL(a_result_from_tail, clk, rst, $rose(reading_valid),
               $past(q_pop && (q_op.kind == dsfp_pkg::OP_TAIL)),
               "reading raised without a tail transaction")
  `ASSERT_IMPL(a_stall_from_push, clk, rst, $rose(byte_stall), $past(q_push),
               "queue filled without a push")
  `ASSERT_IMPL(a_pop_needs_entry, clk, rst, q_pop, q_valid, "pop from an empty queue")

endmodule

@@ verif/frame_checker.sv @@
// ---------------------------------------------------------------------------
// Dust sensor frame checker
// Follows every accepted serial byte through its own copy of the frame
// parser state, queues the readings it predicts and compares each accepted
// reading with the oldest one queued.
// ---------------------------------------------------------------------------
module frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  rx_byte,
  input  logic        reading_valid,
  input  logic        reading_stall,
  input  logic [15:0] pm25_tenths,
  input  logic [15:0] pm10_tenths,
  output int          errors,
  output int          pending,
  output int          readings_seen
);

  typedef struct packed {
    logic [15:0] pm25;
    logic [15:0] pm10;
  } reading_t;

  reading_t    readings_due[$];
  logic [3:0]  hunt_pos;
  logic [7:0]  frame_sum;
  logic        sum_ok;
  logic [7:0]  data_bytes [4];
  int          fails    = 0;
  int          compared = 0;

  task automatic track_byte(input logic [7:0] b);
    logic [3:0] slot;
    slot = hunt_pos - dsfp_pkg::POS_DATA_FIRST;
    case (hunt_pos)
      dsfp_pkg::POS_HUNT: begin
        if (b == dsfp_pkg::HDR_FIRST) hunt_pos = dsfp_pkg::POS_HDR2;
      end
      dsfp_pkg::POS_HDR2: begin
        if (b == dsfp_pkg::HDR_SECOND) begin
          hunt_pos  = dsfp_pkg::POS_DATA_FIRST;
          frame_sum = 8'd0;
          sum_ok    = 1'b0;
        end else begin
          hunt_pos = dsfp_pkg::POS_HUNT;
        end
      end
      dsfp_pkg::POS_CHECK: begin
        sum_ok   = (b == frame_sum);
        hunt_pos = dsfp_pkg::POS_TAIL;
      end
      dsfp_pkg::POS_TAIL: begin
        hunt_pos = dsfp_pkg::POS_HUNT;
        if (b == dsfp_pkg::FRAME_TAIL && sum_ok)
          readings_due.push_back('{pm25: {data_bytes[1], data_bytes[0]},
                                   pm10: {data_bytes[3], data_bytes[2]}});
      end
      default: begin
        if (hunt_pos >= dsfp_pkg::POS_DATA_FIRST && hunt_pos <= dsfp_pkg::POS_DATA_LAST) begin
          if (slot < 4'd4) data_bytes[slot[1:0]] = b;
          frame_sum = frame_sum + b;
          hunt_pos  = hunt_pos + 4'd1;
        end else begin
          hunt_pos = dsfp_pkg::POS_HUNT;
        end
      end
    endcase
  endtask

  task automatic compare_reading();
    reading_t due;
    if (readings_due.size() == 0) begin
      $error("reading with none due: pm25_tenths %0d, pm10_tenths %0d",
             pm25_tenths, pm10_tenths);
      fails++;
    end else begin
      due = readings_due.pop_front();
      compared++;
      if (pm25_tenths !== due.pm25) begin
        $error("pm25_tenths: expected %0d, actual %0d", due.pm25, pm25_tenths);
        fails++;
      end
      if (pm10_tenths !== due.pm10) begin
        $error("pm10_tenths: expected %0d, actual %0d", due.pm10, pm10_tenths);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hunt_pos  = dsfp_pkg::POS_HUNT;
      frame_sum = 8'd0;
      sum_ok    = 1'b0;
    end else begin
      if (reading_valid && !reading_stall) compare_reading();
      if (byte_valid && !byte_stall) track_byte(rx_byte);
    end
    errors        <= fails;
    pending       <= readings_due.size();
    readings_seen <= compared;
  end

endmodule

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// Dust sensor frame parser testbench
// Feeds the parser directed and random byte streams made of good frames,
// damaged frames and line noise, with random idling on both channels and
// one long hold-off on the readings; a checker beside the block predicts
// and compares every reading.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_ITEMS   = 800;
  localparam int CALM_FROM      = 700;
  localparam int HOLD_FROM      = 250;
  localparam int LONG_HOLD      = 150;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {
    FLAW_NONE,
    FLAW_HDR2,
    FLAW_SUM,
    FLAW_TAIL,
    FLAW_SHORT
  } frame_flaw_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        byte_valid    = 1'b0;
  logic        byte_stall;
  logic [7:0]  rx_byte       = 8'd0;
  logic        reading_valid;
  logic        reading_stall = 1'b0;
  logic [15:0] pm25_tenths;
  logic [15:0] pm10_tenths;

  int   errors;
  int   pending;
  int   readings_seen;
  int   items_sent     = 0;
  int   quiet          = 0;
  logic calm           = 1'b0;
  logic long_hold_req  = 1'b0;
  logic long_hold_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dust_sensor_frame_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .rx_byte       (rx_byte),
    .reading_valid (reading_valid),
    .reading_stall (reading_stall),
    .pm25_tenths   (pm25_tenths),
    .pm10_tenths   (pm10_tenths)
  );

  frame_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .rx_byte       (rx_byte),
    .reading_valid (reading_valid),
    .reading_stall (reading_stall),
    .pm25_tenths   (pm25_tenths),
    .pm10_tenths   (pm10_tenths),
    .errors        (errors),
    .pending       (pending),
    .readings_seen (readings_seen)
  );

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    rx_byte    <= b;
    do @(posedge clk); while (byte_stall);
    items_sent++;
  endtask

  task automatic send_frame(input logic [47:0] data, input frame_flaw_t flaw);
    logic [7:0] cs;
    logic [7:0] b;
    int         cut;
    cs  = 8'd0;
    cut = $urandom_range(0, 5);
    for (int i = 0; i < 6; i++) cs = cs + data[8*i +: 8];
    send_byte(dsfp_pkg::HDR_FIRST);
    if (flaw == FLAW_HDR2) begin
      do b = 8'($urandom); while (b == dsfp_pkg::HDR_SECOND);
      send_byte(b);
    end else begin
      send_byte(dsfp_pkg::HDR_SECOND);
    end
    for (int i = 0; i < 6; i++) begin
      if (flaw == FLAW_SHORT && i == cut) return;
      send_byte(data[8*i +: 8]);
    end
    if (flaw == FLAW_SUM) cs = cs ^ 8'($urandom_range(1, 255));
    send_byte(cs);
    if (flaw == FLAW_TAIL) begin
      do b = 8'($urandom); while (b == dsfp_pkg::FRAME_TAIL);
      send_byte(b);
    end else begin
      send_byte(dsfp_pkg::FRAME_TAIL);
    end
  endtask

  // reading side: random stall bursts, one long hold-off, none near the end
  initial begin : reading_side
    forever begin
      if (long_hold_req && !long_hold_done) begin
        reading_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        reading_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        reading_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (reading_valid && !reading_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("FAIL dust_sensor_frame_parser");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : byte_side
    logic [47:0] data;
    int          pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h55);
    send_byte(dsfp_pkg::HDR_FIRST);
    send_byte(dsfp_pkg::HDR_FIRST);
    send_frame({48{1'b1}}, FLAW_NONE);
    send_frame(48'd0, FLAW_NONE);

    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= HOLD_FROM) long_hold_req = 1'b1;
      if (items_sent >= CALM_FROM) calm = 1'b1;
      pick = $urandom_range(0, 9);
      data = ($urandom_range(0, 15) == 0) ? {48{1'b1}} : 48'({$urandom, $urandom});
      if (pick == 0) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 3) begin
        send_frame(data, frame_flaw_t'($urandom_range(FLAW_HDR2, FLAW_SHORT)));
      end else begin
        send_frame(data, FLAW_NONE);
      end
    end
    byte_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d serial bytes of good, damaged and noisy frames;", items_sent);
    $display("compared %0d readings, with one long hold-off on the reading side.",
             readings_seen);
    if (errors == 0 && pending == 0) begin
      $display("PASS dust_sensor_frame_parser");
    end else begin
      $display("FAIL dust_sensor_frame_parser");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dsfp_pkg.sv
rtl/dsfp_front.sv
rtl/dsfp_fifo.sv
rtl/dsfp_back.sv
rtl/dust_sensor_frame_parser.sv
verif/frame_checker.sv
verif/tb_top.sv
